FILE: hw/rtl/tps_pkg.sv
// tps_pkg: shared codes, reset values and types of the tamping pass sequencer
// used by tps_step and tamping_pass_sequencer; depends on nothing else
package tps_pkg;

    // vertical drive codes
    localparam logic [1:0] V_STOP = 2'd0;
    localparam logic [1:0] V_UP   = 2'd1;
    localparam logic [1:0] V_DOWN = 2'd2;

    // horizontal drive codes
    localparam logic [1:0] H_STOP = 2'd0;
    localparam logic [1:0] H_FWD  = 2'd1;
    localparam logic [1:0] H_BACK = 2'd2;

    // program phase codes
    localparam logic [1:0] PH_LOWER  = 2'd0;
    localparam logic [1:0] PH_LIFT   = 2'd1;
    localparam logic [1:0] PH_TRAVEL = 2'd2;

    // fault codes
    localparam logic [1:0] FAULT_NONE   = 2'd0;
    localparam logic [1:0] FAULT_OIL    = 2'd1;
    localparam logic [1:0] FAULT_SAFETY = 2'd2;

    localparam logic [1:0] PROG_IDLE    = 2'd0;
    localparam logic [1:0] LAST_PROGRAM = 2'd3;

    // register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PASSES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAFETY = 3'd4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;
    localparam logic [7:0]  PASS_MAX = 8'hFF;

    // register reset values
    localparam logic [15:0] SETTLE_RST = 16'd2000;
    localparam logic [15:0] LIFT_RST   = 16'd2000;
    localparam logic [15:0] TRAVEL_RST = 16'd400;
    localparam logic [7:0]  PASSES_RST = 8'd2;
    localparam logic [15:0] SAFETY_RST = 16'd15000;

    typedef struct packed {
        logic [15:0] settle_delay_ms;
        logic [15:0] lift_time_ms;
        logic [15:0] travel_time_ms;
        logic [7:0]  pass_limit;
        logic [15:0] safety_time_ms;
    } cfg_t;

    typedef struct packed {
        logic       tick;
        logic       pressure_hit;
        logic       feeler_front;
        logic       feeler_back;
        logic [1:0] start_program;
        logic       stop_request;
        logic       oil_low;
    } item_t;

    typedef struct packed {
        logic [1:0]  prog;
        logic [1:0]  phase;
        logic        awaiting_pressure;
        logic        pressure_once;
        logic [15:0] elapsed_ms;
        logic [15:0] travel_accum_ms;
        logic [7:0]  pass_count;
        logic        dir_forward;
        logic [1:0]  vert_out;
        logic [1:0]  horiz_out;
        logic [1:0]  fault_latch;
    } state_t;

    localparam state_t STATE_RST = '{
        prog:              PROG_IDLE,
        phase:             PH_LOWER,
        awaiting_pressure: 1'b1,
        pressure_once:     1'b0,
        elapsed_ms:        16'd0,
        travel_accum_ms:   16'd0,
        pass_count:        8'd0,
        dir_forward:       1'b1,
        vert_out:          V_STOP,
        horiz_out:         H_STOP,
        fault_latch:       FAULT_NONE
    };

endpackage

FILE: hw/rtl/tps_step.sv
// tps_step: next-state and result logic for one beat of the sequencer
// depends on tps_pkg for codes and the state, config and item structs
module tps_step (
    input  tps_pkg::state_t cur,
    input  tps_pkg::cfg_t   cfg,
    input  tps_pkg::item_t  item,
    output tps_pkg::state_t nxt,
    output logic            finished,
    output logic [1:0]      next_program
);

    always_comb begin
        tps_pkg::state_t s;
        logic            hit;
        logic [16:0]     sum;
        s            = cur;
        finished     = 1'b0;
        next_program = tps_pkg::PROG_IDLE;
        hit          = 1'b0;
        sum          = 17'd0;

        // low oil wins over everything
        if (s.fault_latch == tps_pkg::FAULT_NONE && item.oil_low) begin
            s.fault_latch = tps_pkg::FAULT_OIL;
            s.prog        = tps_pkg::PROG_IDLE;
            s.vert_out    = tps_pkg::V_STOP;
            s.horiz_out   = tps_pkg::H_STOP;
        end

        if (s.fault_latch == tps_pkg::FAULT_NONE) begin
            if (item.stop_request) begin
                s.prog      = tps_pkg::PROG_IDLE;
                s.vert_out  = tps_pkg::V_STOP;
                s.horiz_out = tps_pkg::H_STOP;
            end else if (item.start_program != tps_pkg::PROG_IDLE &&
                         item.start_program != s.prog) begin
                s.prog              = item.start_program;
                s.pass_count        = 8'd0;
                s.dir_forward       = 1'b1;
                s.travel_accum_ms   = 16'd0;
                s.elapsed_ms        = 16'd0;
                s.phase             = tps_pkg::PH_LOWER;
                s.horiz_out         = tps_pkg::H_STOP;
                s.vert_out          = tps_pkg::V_DOWN;
                s.pressure_once     = 1'b0;
                s.awaiting_pressure = 1'b1;
            end
        end

        if (s.fault_latch == tps_pkg::FAULT_NONE && s.prog != tps_pkg::PROG_IDLE) begin
            if (item.tick && s.elapsed_ms != tps_pkg::TIME_MAX) begin
                s.elapsed_ms = s.elapsed_ms + 16'd1;
            end

            case (s.phase)
                tps_pkg::PH_LOWER: begin
                    if (s.awaiting_pressure) begin
                        // two consecutive ticks with pressure
                        if (item.tick) begin
                            if (item.pressure_hit) begin
                                if (s.pressure_once) begin
                                    s.awaiting_pressure = 1'b0;
                                    s.elapsed_ms        = 16'd0;
                                end else begin
                                    s.pressure_once = 1'b1;
                                end
                            end else begin
                                s.pressure_once = 1'b0;
                            end
                        end
                    end else if (s.elapsed_ms >= cfg.settle_delay_ms) begin
                        s.phase      = tps_pkg::PH_LIFT;
                        s.elapsed_ms = 16'd0;
                        s.vert_out   = tps_pkg::V_UP;
                    end
                end
                tps_pkg::PH_LIFT: begin
                    if (s.elapsed_ms >= cfg.lift_time_ms) begin
                        s.vert_out   = tps_pkg::V_STOP;
                        s.horiz_out  = s.dir_forward ? tps_pkg::H_FWD : tps_pkg::H_BACK;
                        s.elapsed_ms = 16'd0;
                        s.phase      = tps_pkg::PH_TRAVEL;
                    end
                end
                default: begin
                    // travelling, also for the unused phase code
                    hit = s.dir_forward ? item.feeler_front : item.feeler_back;
                    sum = {1'b0, s.travel_accum_ms} + {1'b0, s.elapsed_ms};
                    if (hit) begin
                        s.dir_forward     = ~s.dir_forward;
                        s.travel_accum_ms = 16'd0;
                        if (s.pass_count != tps_pkg::PASS_MAX) begin
                            s.pass_count = s.pass_count + 8'd1;
                        end
                        if (s.pass_count >= cfg.pass_limit) begin
                            finished     = 1'b1;
                            next_program = (s.prog == tps_pkg::LAST_PROGRAM)
                                         ? tps_pkg::PROG_IDLE : s.prog + 2'd1;
                            s.prog       = tps_pkg::PROG_IDLE;
                            s.vert_out   = tps_pkg::V_STOP;
                            s.horiz_out  = tps_pkg::H_STOP;
                        end else begin
                            s.phase             = tps_pkg::PH_LOWER;
                            s.horiz_out         = tps_pkg::H_STOP;
                            s.vert_out          = tps_pkg::V_DOWN;
                            s.pressure_once     = 1'b0;
                            s.awaiting_pressure = 1'b1;
                        end
                    end else if (sum >= {1'b0, cfg.safety_time_ms}) begin
                        s.fault_latch = tps_pkg::FAULT_SAFETY;
                        s.prog        = tps_pkg::PROG_IDLE;
                        s.vert_out    = tps_pkg::V_STOP;
                        s.horiz_out   = tps_pkg::H_STOP;
                    end else if (s.elapsed_ms >= cfg.travel_time_ms) begin
                        // accumulated pass time saturates
                        s.travel_accum_ms   = sum[16] ? tps_pkg::TIME_MAX : sum[15:0];
                        s.phase             = tps_pkg::PH_LOWER;
                        s.horiz_out         = tps_pkg::H_STOP;
                        s.vert_out          = tps_pkg::V_DOWN;
                        s.pressure_once     = 1'b0;
                        s.awaiting_pressure = 1'b1;
                    end
                end
            endcase
        end

        nxt = s;
    end

endmodule

FILE: hw/rtl/tamping_pass_sequencer.sv
// tamping_pass_sequencer: top level, one result beat for every input beat
// the result beat is registered, valid in the cycle after its input beat; throughput one
// beat per cycle while m_ready takes each result, else input stalls behind the waiting one
// a waiting result does not block input while m_ready takes it in the same cycle
// synchronous active-low reset: idle, drives stopped, configuration registers at defaults
// depends on tps_pkg and tps_step
module tamping_pass_sequencer (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tps_pkg::CFG_DATA_W-1:0]  cfg_data,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_tick,
    input  logic                            s_pressure_hit,
    input  logic                            s_feeler_front,
    input  logic                            s_feeler_back,
    input  logic [1:0]                      s_start_program,
    input  logic                            s_stop_request,
    input  logic                            s_oil_low,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_vertical_drive,
    output logic [1:0]                      m_horizontal_drive,
    output logic [1:0]                      m_active_program,
    output logic [7:0]                      m_passes_done,
    output logic                            m_moving_forward,
    output logic [1:0]                      m_fault_code,
    output logic                            m_program_finished,
    output logic [1:0]                      m_next_program
);

    tps_pkg::cfg_t   cfg_reg;
    tps_pkg::state_t state_reg;
    tps_pkg::state_t state_next;
    tps_pkg::item_t  item;
    logic            finished;
    logic [1:0]      next_prog;
    logic            m_valid_reg;
    logic            s_beat;

    logic [1:0]      vert_reg;
    logic [1:0]      horiz_reg;
    logic [1:0]      prog_reg;
    logic [7:0]      passes_reg;
    logic            fwd_reg;
    logic [1:0]      fault_reg;
    logic            finished_reg;
    logic [1:0]      next_prog_reg;

    assign cfg_ready = 1'b1;
    assign s_ready   = ~m_valid_reg | m_ready;
    assign s_beat    = s_valid & s_ready;

    assign item = '{
        tick:          s_tick,
        pressure_hit:  s_pressure_hit,
        feeler_front:  s_feeler_front,
        feeler_back:   s_feeler_back,
        start_program: s_start_program,
        stop_request:  s_stop_request,
        oil_low:       s_oil_low
    };

    tps_step u_step (
        .cur          (state_reg),
        .cfg          (cfg_reg),
        .item         (item),
        .nxt          (state_next),
        .finished     (finished),
        .next_program (next_prog)
    );

    // configuration registers, indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_delay_ms <= tps_pkg::SETTLE_RST;
            cfg_reg.lift_time_ms    <= tps_pkg::LIFT_RST;
            cfg_reg.travel_time_ms  <= tps_pkg::TRAVEL_RST;
            cfg_reg.pass_limit      <= tps_pkg::PASSES_RST;
            cfg_reg.safety_time_ms  <= tps_pkg::SAFETY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                tps_pkg::REG_SETTLE: cfg_reg.settle_delay_ms <= cfg_data;
                tps_pkg::REG_LIFT:   cfg_reg.lift_time_ms    <= cfg_data;
                tps_pkg::REG_TRAVEL: cfg_reg.travel_time_ms  <= cfg_data;
                tps_pkg::REG_PASSES: cfg_reg.pass_limit      <= cfg_data[7:0];
                tps_pkg::REG_SAFETY: cfg_reg.safety_time_ms  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tps_pkg::STATE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                state_reg <= state_next;
            end
            if (s_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on every input beat
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            vert_reg      <= state_next.vert_out;
            horiz_reg     <= state_next.horiz_out;
            prog_reg      <= state_next.prog;
            passes_reg    <= state_next.pass_count;
            fwd_reg       <= state_next.dir_forward;
            fault_reg     <= state_next.fault_latch;
            finished_reg  <= finished;
            next_prog_reg <= next_prog;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_vertical_drive   = vert_reg;
    assign m_horizontal_drive = horiz_reg;
    assign m_active_program   = prog_reg;
    assign m_passes_done      = passes_reg;
    assign m_moving_forward   = fwd_reg;
    assign m_fault_code       = fault_reg;
    assign m_program_finished = finished_reg;
    assign m_next_program     = next_prog_reg;

endmodule
